FILE: design/rpn_pkg.sv
package rpn_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int STEP_W      = $clog2(DATA_W);

    // Output beat layout inside m_tdata.
    localparam int OUT_TDATA_W = ((DATA_W + DEPTH_W + 7) / 8) * 8;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

endpackage

FILE: design/rpn_stack_evaluator_unit.sv
// Sequence: push, finish, ignored kinds and underflow or full errors go from the input beat
// straight to S_DONE; add, subtract and divide by zero pass through S_OPER, multiply then
// loops in S_MUL and divide runs S_DNEGA, S_DNEGB, S_DIV and S_DFIX (one shared 33-bit adder,
// one bit per cycle); S_DONE then hands every result to the output register once it is free.
// One token at a time: the next beat is taken once the result moves to the output register.
// Reset (rst_n low, asynchronous) empties the stack and drops any pending output beat.
module rpn_stack_evaluator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rpn_pkg::DATA_W-1:0]         s_tdata,  // [31:0] operand
    input  logic                               s_tlast,  // finish
    input  logic [rpn_pkg::KIND_W-1:0]         s_tuser,  // [2:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rpn_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [31:0] top_value, [38:32] depth
    output logic                               m_tlast,  // is_final
    output logic [rpn_pkg::STATUS_W-1:0]       m_tuser   // [1:0] status
);

    localparam int DW = rpn_pkg::DATA_W;
    localparam int AW = rpn_pkg::ADDR_W;
    localparam int CW = rpn_pkg::DEPTH_W;
    localparam int SW = rpn_pkg::STEP_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OPER  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DNEGA = 3'd3;
    localparam logic [2:0] S_DNEGB = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DFIX  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [CW-1:0]                   depth_reg, depth_next;
    logic [DW-1:0]                   top_reg, top_next;
    logic [rpn_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic                            fin_reg, fin_next;
    logic [rpn_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [DW-1:0]                   a_reg, a_next;
    logic [DW-1:0]                   b_reg, b_next;
    logic [DW-1:0]                   acc_reg, acc_next;
    logic [SW-1:0]                   cnt_reg, cnt_next;
    logic                            negq_reg, negq_next;
    logic                            m_valid_reg, m_valid_next;
    logic [DW-1:0]                   m_top_reg, m_top_next;
    logic [CW-1:0]                   m_depth_reg, m_depth_next;
    logic [rpn_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    logic                            m_last_reg, m_last_next;

    // Stack memory holds every entry below the top; the top lives in top_reg.
    logic [DW-1:0]                   stack_mem [rpn_pkg::STACK_DEPTH];
    logic [DW-1:0]                   rd_data_reg;
    logic                            mem_we;
    logic [CW-1:0]                   rd_addr_full;
    logic [CW-1:0]                   wr_addr_full;

    // Shared adder/subtractor.
    logic [DW-1:0]                   add_x;
    logic [DW-1:0]                   add_y;
    logic                            add_sub;
    logic [DW:0]                     add_sum;
    logic                            out_free;
    logic [DW-1:0]                   res_top;

    assign rd_addr_full = depth_reg - CW'(2);
    assign wr_addr_full = depth_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr_full[AW-1:0]] <= top_reg;
        end
        rd_data_reg <= stack_mem[rd_addr_full[AW-1:0]];
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_OPER:
            begin
                add_x   = rd_data_reg;
                add_y   = top_reg;
                add_sub = (kind_reg == rpn_pkg::KIND_SUB);
            end
            S_MUL:
            begin
                add_x = acc_reg;
                add_y = a_reg[0] ? b_reg : '0;
            end
            S_DNEGA, S_DFIX:
            begin
                add_y   = a_reg;
                add_sub = 1'b1;
            end
            S_DNEGB:
            begin
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            S_DIV:
            begin
                add_x   = {acc_reg[DW-2:0], a_reg[DW-1]};
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    // With subtraction, bit DW of the sum is set when add_x >= add_y.
    assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {{DW{1'b0}}, add_sub};

    assign out_free = !m_valid_reg || m_tready;

    // Top reported in the result beat; a finish reports the top before emptying.
    always_comb
    begin
        if (fin_reg)
        begin
            res_top = (status_reg == rpn_pkg::ST_UNDERFLOW) ? '0 : top_reg;
        end
        else
        begin
            res_top = (depth_reg != '0) ? top_reg : '0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        top_next      = top_reg;
        kind_next     = kind_reg;
        fin_next      = fin_reg;
        status_next   = status_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        negq_next     = negq_reg;
        m_valid_next  = m_valid_reg;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next   = s_tuser;
                    fin_next    = s_tlast;
                    status_next = rpn_pkg::ST_OK;
                    state_next  = S_DONE;
                    if (s_tlast)
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = rpn_pkg::ST_UNDERFLOW;
                        end
                        depth_next = '0;
                    end
                    else
                    begin
                        case (s_tuser)
                            rpn_pkg::KIND_PUSH:
                            begin
                                if (depth_reg >= CW'(rpn_pkg::STACK_DEPTH))
                                begin
                                    status_next = rpn_pkg::ST_FULL;
                                end
                                else
                                begin
                                    mem_we     = (depth_reg != '0);
                                    top_next   = s_tdata;
                                    depth_next = depth_reg + CW'(1);
                                end
                            end
                            rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB,
                            rpn_pkg::KIND_MUL, rpn_pkg::KIND_DIV:
                            begin
                                if (depth_reg < CW'(2))
                                begin
                                    status_next = rpn_pkg::ST_UNDERFLOW;
                                end
                                else
                                begin
                                    state_next = S_OPER;
                                end
                            end
                            default:
                            begin
                                status_next = rpn_pkg::ST_OK;
                            end
                        endcase
                    end
                end
            end

            // Left operand is now in rd_data_reg, right operand is top_reg.
            S_OPER:
            begin
                state_next = S_DONE;
                case (kind_reg)
                    rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB:
                    begin
                        top_next   = add_sum[DW-1:0];
                        depth_next = depth_reg - CW'(1);
                    end
                    rpn_pkg::KIND_MUL:
                    begin
                        a_next     = top_reg;
                        b_next     = rd_data_reg;
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    rpn_pkg::KIND_DIV:
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = rpn_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            a_next     = rd_data_reg;
                            b_next     = top_reg;
                            state_next = S_DNEGA;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Shift-and-add multiply, low word only.
            S_MUL:
            begin
                acc_next = add_sum[DW-1:0];
                a_next   = a_reg >> 1;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(DW - 1))
                begin
                    top_next   = add_sum[DW-1:0];
                    depth_next = depth_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            // Take magnitudes of dividend and divisor.
            S_DNEGA:
            begin
                negq_next = a_reg[DW-1] ^ b_reg[DW-1];
                if (a_reg[DW-1])
                begin
                    a_next = add_sum[DW-1:0];
                end
                state_next = S_DNEGB;
            end

            S_DNEGB:
            begin
                if (b_reg[DW-1])
                begin
                    b_next = add_sum[DW-1:0];
                end
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            // Restoring division: one quotient bit per cycle shifts into a_reg.
            S_DIV:
            begin
                if (add_sum[DW])
                begin
                    acc_next = add_sum[DW-1:0];
                end
                else
                begin
                    acc_next = {acc_reg[DW-2:0], a_reg[DW-1]};
                end
                a_next   = {a_reg[DW-2:0], add_sum[DW]};
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(DW - 1))
                begin
                    state_next = S_DFIX;
                end
            end

            // Apply the quotient sign.
            S_DFIX:
            begin
                top_next   = negq_reg ? add_sum[DW-1:0] : a_reg;
                depth_next = depth_reg - CW'(1);
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_top_next    = res_top;
                    m_depth_next  = depth_reg;
                    m_status_next = status_reg;
                    m_last_next   = fin_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        kind_reg     <= kind_next;
        fin_reg      <= fin_next;
        status_reg   <= status_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        negq_reg     <= negq_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rpn_pkg::OUT_TDATA_W - DW - CW){1'b0}}, m_depth_reg, m_top_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

FILE: design/rpn_checker.sv
module rpn_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [rpn_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tlast,
    input  logic [rpn_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int DW = rpn_pkg::DATA_W;
    localparam int CW = rpn_pkg::DEPTH_W;

    // A stalled output beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // The unit is not ready in the cycle after taking a token.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // A finish beat always reports an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[DW+CW-1:DW] == '0)
        else $error("finish beat with nonzero depth");

    // A full-stack error is only reported at full depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == rpn_pkg::ST_FULL
            |-> m_tdata[DW+CW-1:DW] == CW'(rpn_pkg::STACK_DEPTH) && !m_tlast)
        else $error("stack full status at wrong depth");

    // A divide by zero leaves both operands on the stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == rpn_pkg::ST_DIVZERO
            |-> m_tdata[DW+CW-1:DW] >= CW'(2) && m_tdata[DW-1:0] == '0 && !m_tlast)
        else $error("divide by zero beat inconsistent");

endmodule

bind rpn_stack_evaluator_unit rpn_checker u_rpn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
